// ===== rtl/spg_pkg.sv =====
// Package for the stepper pulse generator.
// Holds the shared types, codes and constants; no dependencies.
`default_nettype none

package spg_pkg;

	// Field widths fixed by the interface
	localparam int FUNC_W   = 2;
	localparam int CHAN_W   = 3;
	localparam int WORD_W   = 16;
	localparam int LINES_W  = 6;
	localparam int CFG_IDX_W = 3;
	localparam int NUM_CFG_REGS = 6;

	// Defaults
	localparam int CHANNELS_DEF = 6;
	localparam logic [WORD_W-1:0] HALF_RESET = 16'd20;

	// Command codes
	typedef enum logic [FUNC_W-1:0] {
		FUNC_TICK = 2'd0,
		FUNC_RUN  = 2'd1,
		FUNC_STOP = 2'd2
	} func_t;

	// Channel run mode
	typedef enum logic [1:0] {
		MODE_OFF = 2'd0,
		MODE_FWD = 2'd1,
		MODE_BWD = 2'd2
	} run_mode_t;

	// Command seen by one channel for the accepted word
	typedef struct packed {
		logic              tick;
		logic              run;
		logic              stop;
		logic [WORD_W-1:0] count;
	} chan_cmd_t;

	// Channel status after the accepted word
	typedef struct packed {
		logic              step;
		logic              dir;
		logic              enable;
		logic [WORD_W-1:0] position;
		logic [WORD_W-1:0] pulses;
		logic              busy;
	} chan_stat_t;

	// One result word
	typedef struct packed {
		logic [LINES_W-1:0] step_lines;
		logic [LINES_W-1:0] dir_lines;
		logic [LINES_W-1:0] enable_lines;
		logic [WORD_W-1:0]  position;
		logic [WORD_W-1:0]  pulses_left;
		logic               busy_res;
	} res_t;

endpackage

`default_nettype wire

// ===== rtl/spg_channel.sv =====
// One step channel: half-period register, divider, pulse counter, position.
// Depends on spg_pkg.
`default_nettype none

module spg_channel (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      hp_we,
	input  wire logic [spg_pkg::WORD_W-1:0] hp_data,
	input  wire spg_pkg::chan_cmd_t        cmd,
	output spg_pkg::chan_stat_t            stat
);

	logic [spg_pkg::WORD_W-1:0] half_q;
	logic [spg_pkg::WORD_W-1:0] pulses_q, pulses_d;
	logic [spg_pkg::WORD_W-1:0] div_q, div_d;
	logic [spg_pkg::WORD_W-1:0] pos_q, pos_d;
	logic                       level_q, level_d;
	logic                       armed_q, armed_d;
	logic                       enabled_q, enabled_d;
	spg_pkg::run_mode_t         mode_q, mode_d;

	logic                       cnt_neg;
	logic                       cnt_fwd;
	logic [spg_pkg::WORD_W-1:0] cnt_mag;

	// Run request: positive runs forward, zero or negative runs backward
	assign cnt_neg = cmd.count[spg_pkg::WORD_W-1];
	assign cnt_fwd = !cnt_neg && (cmd.count != '0);
	assign cnt_mag = cnt_fwd ? cmd.count : (~cmd.count + 1'b1);

	// Next state for this word
	always_comb begin
		pulses_d  = pulses_q;
		div_d     = div_q;
		pos_d     = pos_q;
		level_d   = level_q;
		armed_d   = armed_q;
		enabled_d = enabled_q;
		mode_d    = mode_q;
		if (cmd.run) begin
			mode_d    = cnt_fwd ? spg_pkg::MODE_FWD : spg_pkg::MODE_BWD;
			div_d     = '0;
			pulses_d  = cnt_mag;
			level_d   = 1'b0;
			enabled_d = 1'b1;
			armed_d   = 1'b1;
		end else if (cmd.stop) begin
			mode_d    = spg_pkg::MODE_OFF;
			div_d     = '0;
			pulses_d  = '0;
			level_d   = 1'b0;
			enabled_d = 1'b0;
			armed_d   = 1'b0;
		end else if (cmd.tick && armed_q && (pulses_q != '0)) begin
			if (div_q != '0) begin
				div_d = div_q - 1'b1;
			end else begin
				div_d   = half_q;
				level_d = !level_q;
				// falling edge ends one pulse
				if (level_q) begin
					pulses_d = pulses_q - 1'b1;
					pos_d    = (mode_q == spg_pkg::MODE_FWD) ? pos_q + 1'b1 : pos_q - 1'b1;
				end
			end
		end
	end

	// State registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_q    <= spg_pkg::HALF_RESET;
			pulses_q  <= '0;
			div_q     <= '0;
			pos_q     <= '0;
			level_q   <= 1'b0;
			armed_q   <= 1'b0;
			enabled_q <= 1'b0;
			mode_q    <= spg_pkg::MODE_OFF;
		end else begin
			if (hp_we) begin
				half_q <= hp_data;
			end
			pulses_q  <= pulses_d;
			div_q     <= div_d;
			pos_q     <= pos_d;
			level_q   <= level_d;
			armed_q   <= armed_d;
			enabled_q <= enabled_d;
			mode_q    <= mode_d;
		end
	end

	// Status after this word
	assign stat.step     = level_d;
	assign stat.dir      = (mode_d == spg_pkg::MODE_BWD);
	assign stat.enable   = enabled_d;
	assign stat.position = pos_d;
	assign stat.pulses   = pulses_d;
	assign stat.busy     = armed_d && (pulses_d != '0);

endmodule

`default_nettype wire

// ===== rtl/spg_out_buf.sv =====
// Result register with a skid stage, valid/stall on both sides.
// Depends on spg_pkg.
`default_nettype none

module spg_out_buf (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire spg_pkg::res_t push_data,
	output logic               full,
	output logic               out_valid,
	input  wire logic          out_stall,
	output spg_pkg::res_t      out_data
);

	logic          out_vld_q;
	logic          skid_vld_q;
	spg_pkg::res_t out_q;
	spg_pkg::res_t skid_q;
	logic          pop;

	assign pop       = out_vld_q && !out_stall;
	assign full      = skid_vld_q;
	assign out_valid = out_vld_q;
	assign out_data  = out_q;

	// Valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else begin
			if (pop) begin
				if (skid_vld_q) begin
					skid_vld_q <= 1'b0;
				end else begin
					out_vld_q <= push;
				end
			end else if (push) begin
				if (out_vld_q) begin
					skid_vld_q <= 1'b1;
				end else begin
					out_vld_q <= 1'b1;
				end
			end
		end
	end

	// Payload
	always_ff @(posedge clk) begin
		if (pop) begin
			if (skid_vld_q) begin
				out_q <= skid_q;
			end else if (push) begin
				out_q <= push_data;
			end
		end else if (push) begin
			if (out_vld_q) begin
				skid_q <= push_data;
			end else begin
				out_q <= push_data;
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/stepper_pulse_generator_unit.sv =====
// Stepper pulse generator, top level.
// Depends on spg_pkg, spg_channel and spg_out_buf.
//
// Usage:
//   Input words (func, channel, step_req) use in_valid/in_stall; result
//   words use out_valid/out_stall. func TICK advances every armed channel's
//   divider, RUN arms the addressed channel, STOP clears it. Every accepted
//   word yields exactly one result: the six step, direction and enable
//   lines plus position, pulses_left and busy of the addressed channel,
//   all as they stand after that word.
//   Throughput: one word per cycle while in_stall is low; all channels
//   update in parallel in their own registers and the result is formed
//   in the same cycle, then registered. A stalled receiver is absorbed
//   by a one-word skid stage; in_stall rises only when both the result
//   register and the skid stage are full. Reset: all channels off, positions
//   zero, half periods 20, no result pending. Half-period registers are
//   written through wr_en/wr_index/wr_data while the block is idle, a rule
//   for the user, not enforced by the block; indexes 6 and 7 are ignored.
`default_nettype none

module stepper_pulse_generator_unit #(
	parameter int CHANNELS = spg_pkg::CHANNELS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// configuration
	input  wire logic                          wr_en,
	input  wire logic [spg_pkg::CFG_IDX_W-1:0] wr_index,
	input  wire logic [spg_pkg::WORD_W-1:0]    wr_data,
	// input words
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic [spg_pkg::FUNC_W-1:0]    func,
	input  wire logic [spg_pkg::CHAN_W-1:0]    channel,
	input  wire logic signed [spg_pkg::WORD_W-1:0] step_req,
	// result words
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic [spg_pkg::LINES_W-1:0]        step_lines,
	output logic [spg_pkg::LINES_W-1:0]        dir_lines,
	output logic [spg_pkg::LINES_W-1:0]        enable_lines,
	output logic [spg_pkg::WORD_W-1:0]         position,
	output logic [spg_pkg::WORD_W-1:0]         pulses_left,
	output logic                               busy_res
);

	logic                buf_full;
	logic                in_acc;
	logic                is_tick;
	logic                is_run;
	logic                is_stop;
	spg_pkg::chan_stat_t stat [CHANNELS];
	spg_pkg::chan_stat_t sel_stat;
	logic                sel_hit;
	spg_pkg::res_t       res;
	spg_pkg::res_t       out_data;

	assign in_stall = buf_full;
	assign in_acc   = in_valid && !buf_full;

	// Command decode
	always_comb begin
		is_tick = 1'b0;
		is_run  = 1'b0;
		is_stop = 1'b0;
		case (spg_pkg::func_t'(func))
			spg_pkg::FUNC_TICK: is_tick = in_acc;
			spg_pkg::FUNC_RUN:  is_run  = in_acc;
			spg_pkg::FUNC_STOP: is_stop = in_acc;
			default: ;
		endcase
	end

	// Channels
	for (genvar c = 0; c < CHANNELS; c++) begin : g_ch
		spg_pkg::chan_cmd_t cmd;
		logic               hit;
		logic               hp_we;

		assign hit       = (32'(channel) == c);
		assign cmd.tick  = is_tick;
		assign cmd.run   = is_run && hit;
		assign cmd.stop  = is_stop && hit;
		assign cmd.count = step_req;
		assign hp_we     = wr_en && (32'(wr_index) == c) && (c < spg_pkg::NUM_CFG_REGS);

		spg_channel u_ch (
			.clk     (clk),
			.arst_n  (arst_n),
			.hp_we   (hp_we),
			.hp_data (wr_data),
			.cmd     (cmd),
			.stat    (stat[c])
		);
	end

	// Addressed channel select
	always_comb begin
		sel_stat = '0;
		sel_hit  = 1'b0;
		for (int c = 0; c < CHANNELS; c++) begin
			if (32'(channel) == c) begin
				sel_stat = stat[c];
				sel_hit  = 1'b1;
			end
		end
	end

	// Line fields cover the first six channels
	for (genvar b = 0; b < spg_pkg::LINES_W; b++) begin : g_line
		if (b < CHANNELS) begin : g_on
			assign res.step_lines[b]   = stat[b].step;
			assign res.dir_lines[b]    = stat[b].dir;
			assign res.enable_lines[b] = stat[b].enable;
		end else begin : g_off
			assign res.step_lines[b]   = 1'b0;
			assign res.dir_lines[b]    = 1'b0;
			assign res.enable_lines[b] = 1'b0;
		end
	end

	assign res.position    = sel_hit ? sel_stat.position : '0;
	assign res.pulses_left = sel_hit ? sel_stat.pulses : '0;
	assign res.busy_res    = sel_hit && sel_stat.busy;

	// Result register and skid stage
	spg_out_buf u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (in_acc),
		.push_data (res),
		.full      (buf_full),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	assign step_lines   = out_data.step_lines;
	assign dir_lines    = out_data.dir_lines;
	assign enable_lines = out_data.enable_lines;
	assign position     = out_data.position;
	assign pulses_left  = out_data.pulses_left;
	assign busy_res     = out_data.busy_res;

endmodule

`default_nettype wire

// ===== tb/tb_stepper_pulse_generator_unit.sv =====
// Testbench for stepper_pulse_generator_unit: directed table, then random command words.
// Depends on spg_pkg and the stepper_pulse_generator_unit RTL; predicts each result word unless a row gives it.
`default_nettype none

module tb_stepper_pulse_generator_unit;
	timeunit 1ns;
	timeprecision 1ps;

	import spg_pkg::*;

	localparam int CH_N = CHANNELS_DEF;
	localparam int QUIET_LIMIT = 2000;
	localparam int SETTLE_CYCLES = 4;
	localparam int NUM_PHASES = 8;
	localparam int WORDS_PER_PHASE = 125;
	// func code with no command behind it
	localparam logic [FUNC_W-1:0] FUNC_NOP = 2'd3;

	// One row of the directed table; want is only used when typed is set
	typedef struct packed {
		logic [FUNC_W-1:0] op;
		logic [CHAN_W-1:0] ch;
		logic [WORD_W-1:0] cnt;
		logic              typed;
		res_t              want;
	} cmd_row_t;

	localparam res_t NO_WANT = '0;
	localparam int DIR_ROWS = 25;

	// Half periods in force: ch0 = 0, ch1 = 1, the rest 20
	localparam cmd_row_t dir_rows [0:DIR_ROWS-1] = '{
		'{FUNC_TICK, 3'd0, 16'h0000, 1'b1, '{6'h00, 6'h00, 6'h00, 16'h0000, 16'h0000, 1'b0}},
		// zero count: backward, enabled, never busy
		'{FUNC_RUN,  3'd0, 16'h0000, 1'b1, '{6'h00, 6'h01, 6'h01, 16'h0000, 16'h0000, 1'b0}},
		'{FUNC_TICK, 3'd0, 16'h7FFF, 1'b1, '{6'h00, 6'h01, 6'h01, 16'h0000, 16'h0000, 1'b0}},
		'{FUNC_RUN,  3'd0, 16'h0003, 1'b1, '{6'h00, 6'h00, 6'h01, 16'h0000, 16'h0003, 1'b1}},
		// three full pulses at half period zero
		'{FUNC_TICK, 3'd0, 16'hFFFF, 1'b0, NO_WANT},
		'{FUNC_TICK, 3'd0, 16'h0000, 1'b0, NO_WANT},
		'{FUNC_TICK, 3'd0, 16'h8000, 1'b0, NO_WANT},
		'{FUNC_TICK, 3'd0, 16'h0001, 1'b0, NO_WANT},
		'{FUNC_TICK, 3'd0, 16'h0000, 1'b0, NO_WANT},
		'{FUNC_TICK, 3'd0, 16'h0000, 1'b0, NO_WANT},
		// most negative count gives 32768 backward pulses
		'{FUNC_RUN,  3'd1, 16'h8000, 1'b1, '{6'h00, 6'h02, 6'h03, 16'h0000, 16'h8000, 1'b1}},
		// run while running restarts with the new count
		'{FUNC_RUN,  3'd1, 16'hFFFF, 1'b0, NO_WANT},
		'{FUNC_TICK, 3'd1, 16'h0000, 1'b0, NO_WANT},
		'{FUNC_TICK, 3'd1, 16'h0000, 1'b0, NO_WANT},
		'{FUNC_TICK, 3'd1, 16'h0000, 1'b0, NO_WANT},
		'{FUNC_RUN,  3'd2, 16'h7FFF, 1'b0, NO_WANT},
		'{FUNC_TICK, 3'd2, 16'h0000, 1'b0, NO_WANT},
		'{FUNC_STOP, 3'd2, 16'h0000, 1'b0, NO_WANT},
		// stop keeps the position
		'{FUNC_STOP, 3'd0, 16'hFFFF, 1'b0, NO_WANT},
		// channel out of range
		'{FUNC_RUN,  3'd6, 16'h0005, 1'b0, NO_WANT},
		'{FUNC_STOP, 3'd7, 16'h0000, 1'b0, NO_WANT},
		// unused func value
		'{FUNC_NOP,  3'd5, 16'h5555, 1'b0, NO_WANT},
		'{FUNC_RUN,  3'd5, 16'h0001, 1'b0, NO_WANT},
		'{FUNC_TICK, 3'd5, 16'hAAAA, 1'b0, NO_WANT},
		'{FUNC_STOP, 3'd1, 16'h0000, 1'b0, NO_WANT}
	};

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       wr_en = 1'b0;
	logic [CFG_IDX_W-1:0]       wr_index = '0;
	logic [WORD_W-1:0]          wr_data = '0;
	logic                       in_valid = 1'b0;
	logic                       in_stall;
	logic [FUNC_W-1:0]          func = '0;
	logic [CHAN_W-1:0]          channel = '0;
	logic signed [WORD_W-1:0]   step_req = '0;
	logic                       out_valid;
	logic                       out_stall = 1'b0;
	logic [LINES_W-1:0]         step_lines;
	logic [LINES_W-1:0]         dir_lines;
	logic [LINES_W-1:0]         enable_lines;
	logic [WORD_W-1:0]          position;
	logic [WORD_W-1:0]          pulses_left;
	logic                       busy_res;

	stepper_pulse_generator_unit i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.wr_en        (wr_en),
		.wr_index     (wr_index),
		.wr_data      (wr_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.func         (func),
		.channel      (channel),
		.step_req     (step_req),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.step_lines   (step_lines),
		.dir_lines    (dir_lines),
		.enable_lines (enable_lines),
		.position     (position),
		.pulses_left  (pulses_left),
		.busy_res     (busy_res)
	);

	always #5 clk = ~clk;

	// Channel state as the predictor sees it
	logic [WORD_W-1:0] half_reg  [CH_N];
	logic [WORD_W-1:0] pulse_rem [CH_N];
	logic [WORD_W-1:0] div_cnt   [CH_N];
	logic [WORD_W-1:0] step_pos  [CH_N];
	logic              step_lvl  [CH_N];
	logic              armed     [CH_N];
	logic              drv_en    [CH_N];
	run_mode_t         chan_mode [CH_N];

	res_t              pending_res [$];
	logic [WORD_W-1:0] cfg_next [8];
	int                send_idle_pct = 0;
	int                stall_pct = 0;
	int                mismatches = 0;
	int                n_results = 0;
	int                n_tick = 0, n_run = 0, n_stop = 0, n_other = 0;
	int                quiet_cycles = 0;
	res_t              oldest;

	// Apply one command word to the channel state and return the result word
	function automatic res_t apply_command(input logic [FUNC_W-1:0] op,
			input logic [CHAN_W-1:0] ch, input logic [WORD_W-1:0] cnt);
		res_t r;
		logic in_range;
		r = '0;
		in_range = (ch < CH_N);
		if (op == FUNC_TICK) begin
			for (int c = 0; c < CH_N; c++) begin
				if (armed[c] && pulse_rem[c] != 0) begin
					if (div_cnt[c] != 0) begin
						div_cnt[c] = div_cnt[c] - 1'b1;
					end else begin
						div_cnt[c] = half_reg[c];
						if (!step_lvl[c]) begin
							step_lvl[c] = 1'b1;
						end else begin
							// falling edge: one pulse done
							step_lvl[c] = 1'b0;
							pulse_rem[c] = pulse_rem[c] - 1'b1;
							if (chan_mode[c] == MODE_FWD)
								step_pos[c] = step_pos[c] + 1'b1;
							else
								step_pos[c] = step_pos[c] - 1'b1;
						end
					end
				end
			end
		end else if (op == FUNC_RUN && in_range) begin
			// positive is forward; zero and negative run backward for the magnitude
			if (!cnt[WORD_W-1] && cnt != 0) begin
				chan_mode[ch] = MODE_FWD;
				pulse_rem[ch] = cnt;
			end else begin
				chan_mode[ch] = MODE_BWD;
				pulse_rem[ch] = -cnt;
			end
			div_cnt[ch] = '0;
			step_lvl[ch] = 1'b0;
			drv_en[ch] = 1'b1;
			armed[ch] = 1'b1;
		end else if (op == FUNC_STOP && in_range) begin
			pulse_rem[ch] = '0;
			div_cnt[ch] = '0;
			step_lvl[ch] = 1'b0;
			chan_mode[ch] = MODE_OFF;
			armed[ch] = 1'b0;
			drv_en[ch] = 1'b0;
		end
		for (int c = 0; c < CH_N && c < LINES_W; c++) begin
			r.step_lines[c] = step_lvl[c];
			r.dir_lines[c] = (chan_mode[c] == MODE_BWD);
			r.enable_lines[c] = drv_en[c];
		end
		if (in_range) begin
			r.position = step_pos[ch];
			r.pulses_left = pulse_rem[ch];
			r.busy_res = armed[ch] && pulse_rem[ch] != 0;
		end
		return r;
	endfunction

	function automatic void check_field(input string name, input logic [WORD_W-1:0] exp_v,
			input logic [WORD_W-1:0] act_v);
		if (exp_v !== act_v) begin
			$error("%s: expected %0h, got %0h", name, exp_v, act_v);
			mismatches++;
		end
	endfunction

	// Present one command word, wait for it to be taken, queue its result
	task automatic send_word(input logic [FUNC_W-1:0] op, input logic [CHAN_W-1:0] ch,
			input logic [WORD_W-1:0] cnt, input logic typed, input res_t want);
		res_t pred;
		while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		func <= op;
		channel <= ch;
		step_req <= cnt;
		@(posedge clk);
		while (in_stall !== 1'b0)
			@(posedge clk);
		pred = apply_command(op, ch, cnt);
		pending_res.push_back(typed ? want : pred);
		case (op)
			FUNC_TICK: n_tick++;
			FUNC_RUN:  n_run++;
			FUNC_STOP: n_stop++;
			default:   n_other++;
		endcase
	endtask

	// Stop sending and let every queued result come out
	task automatic drain_results();
		in_valid <= 1'b0;
		while (pending_res.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write cfg_next[0..n_regs-1]; indexes past the channel count are ignored by the block
	task automatic load_half_periods(input int n_regs);
		for (int i = 0; i < n_regs; i++) begin
			wr_en <= 1'b1;
			wr_index <= CFG_IDX_W'(i);
			wr_data <= cfg_next[i];
			@(posedge clk);
			if (i < CH_N)
				half_reg[i] = cfg_next[i];
		end
		wr_en <= 1'b0;
	endtask

	// Receiver stall pattern
	always @(posedge clk)
		out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);

	// Compare each taken result word with the oldest prediction
	always @(posedge clk) begin
		if (arst_n && out_valid === 1'b1 && out_stall == 1'b0) begin
			n_results++;
			if (pending_res.size() == 0) begin
				$error("result word arrived with none expected");
				mismatches++;
			end else begin
				oldest = pending_res.pop_front();
				check_field("step_lines", WORD_W'(oldest.step_lines), WORD_W'(step_lines));
				check_field("dir_lines", WORD_W'(oldest.dir_lines), WORD_W'(dir_lines));
				check_field("enable_lines", WORD_W'(oldest.enable_lines),
					WORD_W'(enable_lines));
				check_field("position", oldest.position, position);
				check_field("pulses_left", oldest.pulses_left, pulses_left);
				check_field("busy_res", WORD_W'(oldest.busy_res), WORD_W'(busy_res));
			end
		end
	end

	// Watchdog: too long without any word moving on either side
	always @(posedge clk) begin
		if (arst_n && ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall)))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	initial begin
		int useful;
		int pick;
		logic [FUNC_W-1:0] op;
		logic [CHAN_W-1:0] ch;
		logic [WORD_W-1:0] cnt;

		for (int c = 0; c < CH_N; c++) begin
			half_reg[c] = HALF_RESET;
			pulse_rem[c] = '0;
			div_cnt[c] = '0;
			step_pos[c] = '0;
			step_lvl[c] = 1'b0;
			armed[c] = 1'b0;
			drv_en[c] = 1'b0;
			chan_mode[c] = MODE_OFF;
		end

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: fast channels 0 and 1, the rest at reset value
		cfg_next[0] = 16'd0;
		cfg_next[1] = 16'd1;
		load_half_periods(2);
		for (int i = 0; i < DIR_ROWS; i++)
			send_word(dir_rows[i].op, dir_rows[i].ch, dir_rows[i].cnt, dir_rows[i].typed,
				dir_rows[i].want);
		drain_results();

		// Random part: mostly ticks with runs and stops mixed in
		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			for (int i = 0; i < 8; i++)
				cfg_next[i] = WORD_W'($urandom_range(3));
			case (ph)
				0: for (int i = 0; i < 8; i++) cfg_next[i] = 16'd0;
				2: begin
					cfg_next[0] = 16'd60000;
					cfg_next[1] = 16'd0;
					cfg_next[2] = 16'hFFFF;
					cfg_next[3] = 16'd1;
					cfg_next[4] = 16'd2;
					cfg_next[5] = 16'd3;
					cfg_next[6] = WORD_W'($urandom);
					cfg_next[7] = WORD_W'($urandom);
				end
				4: for (int i = 0; i < 8; i++) cfg_next[i] = WORD_W'($urandom_range(20));
				6: begin
					cfg_next[0] = 16'd1;
					cfg_next[1] = 16'd0;
					cfg_next[4] = 16'd60000;
				end
				default: ;
			endcase
			load_half_periods(ph == 2 ? 8 : CH_N);

			case (ph % 4)
				0: begin send_idle_pct = 0;  stall_pct = 0;  end
				1: begin send_idle_pct = 51; stall_pct = 0;  end
				2: begin send_idle_pct = 0;  stall_pct = 51; end
				default: begin send_idle_pct = 10; stall_pct = 10; end
			endcase

			useful = 0;
			while (useful < WORDS_PER_PHASE) begin
				pick = $urandom_range(99);
				if (pick < 68)
					op = FUNC_TICK;
				else if (pick < 84)
					op = FUNC_RUN;
				else if (pick < 95)
					op = FUNC_STOP;
				else
					op = FUNC_NOP;
				ch = ($urandom_range(9) == 0) ? CHAN_W'($urandom_range(7, CH_N))
					: CHAN_W'($urandom_range(CH_N - 1));
				pick = $urandom_range(9);
				if (pick < 6) begin
					// short runs so channels finish and go idle again
					cnt = WORD_W'($urandom_range(12));
					if ($urandom_range(1))
						cnt = -cnt;
				end else if (pick < 8) begin
					cnt = WORD_W'($urandom);
				end else if (pick == 8) begin
					case ($urandom_range(3))
						0: cnt = 16'h8000;
						1: cnt = 16'h7FFF;
						2: cnt = 16'hFFFF;
						default: cnt = 16'h0001;
					endcase
				end else begin
					cnt = '0;
				end
				send_word(op, ch, cnt, 1'b0, NO_WANT);
				if (!(op == FUNC_NOP || (op != FUNC_TICK && ch >= CH_N)))
					useful++;
			end
			drain_results();
		end

		send_idle_pct = 0;
		stall_pct = 0;
		drain_results();
		mismatches += pending_res.size();

		$display("covered %0d tick, %0d run, %0d stop and %0d unused-code words, %0d results",
			n_tick, n_run, n_stop, n_other, n_results);
		$display("over %0d phases of half-period settings and idle/stall mixes",
			NUM_PHASES);
		if (mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

`default_nettype wire
